>>> rtl/core/shlt_pkg.sv
package shlt_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned HashAddA          = 23;
  localparam int unsigned HashAddB          = 65537;
  localparam int unsigned EntryIdxW         = 8;

  // controller to datapath
  typedef struct packed {
    logic accept;  // take the input item
    logic scan;    // advance the table walk
    logic finish;  // load the result register, append on a miss when the table has room
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;  // offered item is a terminator or a direct add
    logic match;      // compared entry equals the key
    logic exhausted;  // every valid entry compared without a match
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

>>> rtl/core/shlt_ctrl.sv
module shlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  shlt_pkg::status_t status_i,
  output shlt_pkg::cmd_t    cmd_o,
  output logic             in_ready_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done;

  assign done       = status_i.match || status_i.exhausted;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.is_lookup ? StScan : StMul;
        end
      end
      StMul: begin
        state_d = StIdle;
      end
      StScan: begin
        // freeze the walk while the result register is still occupied
        if (done) begin
          if (status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/shlt_dp.sv
module shlt_dp #(
  parameter int unsigned TABLE_DEPTH = shlt_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shlt_pkg::cmd_t    cmd_i,
  output shlt_pkg::status_t status_o,
  input  logic              kind_i,
  input  logic [7:0]        char_byte_i,
  input  logic [31:0]       given_hash_i,
  input  logic [31:0]       text_handle_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [31:0]       result_handle_o,
  output logic              hit_o,
  output logic              table_full_o,
  output logic [7:0]        entry_index_o,
  output logic [31:0]       hash_out_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW   = shlt_pkg::EntryIdxW;

  logic [31:0]     hash_q;
  logic [15:0]     pos_q;
  logic [7:0]      byte_q;
  logic [31:0]     weight_q;
  logic [31:0]     key_q;
  logic [31:0]     handle_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rd_idx_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_vld_q;
  logic [31:0]     rd_hash_q;
  logic [31:0]     rd_handle_q;
  logic            out_valid_q;
  logic            mul_pending_q;

  logic [31:0] mem_hash   [TABLE_DEPTH];
  logic [31:0] mem_handle [TABLE_DEPTH];

  logic [31:0]        fac_a, fac_b, weight_d, sval;
  logic               is_lookup, issue, room, wr_en;
  logic [IdxW+EW-1:0] cmp_idx_ext;
  logic [CntW+EW-1:0] count_ext;

  assign is_lookup = kind_i || (char_byte_i == 8'd0);
  assign fac_a     = {16'd0, pos_q} + 32'(shlt_pkg::HashAddA);
  assign fac_b     = {16'd0, pos_q} + 32'(shlt_pkg::HashAddB);
  assign weight_d  = fac_a * fac_b;
  assign sval      = {{24{byte_q[7]}}, byte_q};
  assign issue     = cmd_i.scan && (rd_idx_q < count_q);
  assign room      = (count_q < CntW'(TABLE_DEPTH));
  assign wr_en     = cmd_i.finish && !status_o.match && room;
  assign cmp_idx_ext = {{EW{1'b0}}, cmp_idx_q};
  assign count_ext   = {{EW{1'b0}}, count_q};

  assign status_o.is_lookup = is_lookup;
  assign status_o.match     = cmp_vld_q && (rd_hash_q == key_q);
  assign status_o.exhausted = !cmp_vld_q && (rd_idx_q == count_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // string hash and table walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= '0;
      pos_q     <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (is_lookup) begin
          rd_idx_q  <= '0;
          cmp_vld_q <= 1'b0;
          if (!kind_i) begin
            hash_q <= '0;
            pos_q  <= '0;
          end
        end
      end else if (cmd_i.scan) begin
        cmp_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
      end else if (!cmd_i.finish && mul_pending_q) begin
        // second multiply of a string byte
        hash_q <= hash_q + sval * weight_q;
        pos_q  <= pos_q + 16'd1;
      end
      if (wr_en) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // the byte update runs once, in the cycle after a byte item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_pending_q <= 1'b0;
    end else begin
      mul_pending_q <= cmd_i.accept && !is_lookup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q   <= char_byte_i;
      weight_q <= weight_d;
      key_q    <= kind_i ? given_hash_i : hash_q;
      handle_q <= text_handle_i;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_hash[count_q[IdxW-1:0]]   <= key_q;
      mem_handle[count_q[IdxW-1:0]] <= handle_q;
    end
    if (issue) begin
      rd_hash_q   <= mem_hash[rd_idx_q[IdxW-1:0]];
      rd_handle_q <= mem_handle[rd_idx_q[IdxW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hash_out_o <= key_q;
      priority if (status_o.match) begin
        result_handle_o <= rd_handle_q;
        hit_o           <= 1'b1;
        table_full_o    <= 1'b0;
        entry_index_o   <= cmp_idx_ext[EW-1:0];
      end else if (room) begin
        result_handle_o <= handle_q;
        hit_o           <= 1'b0;
        table_full_o    <= 1'b0;
        entry_index_o   <= count_ext[EW-1:0];
      end else begin
        result_handle_o <= handle_q;
        hit_o           <= 1'b0;
        table_full_o    <= 1'b1;
        entry_index_o   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/string_hash_lookup_table_unit.sv
// String hash lookup table.
// Input channel: in_valid_i / in_stall_o carry one item: a string byte
// (kind_i = 0) or a direct add of given_hash_i (kind_i = 1). Output channel:
// out_valid_o / out_stall_i carry one result per terminator or direct add.
// A nonzero byte is handled in two steps: one multiply for the position weight,
// then one for the byte times weight added into the running hash.
// A terminator or direct add walks the table in insertion order, one entry
// per cycle through the registered memory read port; a miss appends the
// entry as the result loads.
// A full table on a miss sets table_full_o and does not insert.
// The result register lets the next item be taken while a result waits;
// a walk that finishes while the receiver stalls holds until it is taken.
// Reset clears the running hash, position and entry count; table contents
// need no clearing, only entries below the count are ever read.
module string_hash_lookup_table_unit #(
  parameter int unsigned TABLE_DEPTH = shlt_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  char_byte_i,
  input  logic [31:0] given_hash_i,
  input  logic [31:0] text_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_handle_o,
  output logic        hit_o,
  output logic        table_full_o,
  output logic [7:0]  entry_index_o,
  output logic [31:0] hash_out_o
);

  shlt_pkg::cmd_t    cmd;
  shlt_pkg::status_t status;
  logic              in_ready;

  assign in_stall_o = !in_ready;

  shlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  shlt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .char_byte_i     (char_byte_i),
    .given_hash_i    (given_hash_i),
    .text_handle_i   (text_handle_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .result_handle_o (result_handle_o),
    .hit_o           (hit_o),
    .table_full_o    (table_full_o),
    .entry_index_o   (entry_index_o),
    .hash_out_o      (hash_out_o)
  );

  a_new_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result appeared without a finished lookup");

  a_hit_excludes_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && table_full_o))
    else $error("hit and table_full both set");

  a_full_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (entry_index_o == 8'd0))
    else $error("full result with nonzero index");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule
